// ===== sv/sync_framed_packet_parser_macros.svh =====
// Assertion macros shared by the framed packet parser RTL.
`ifndef SYNC_FRAMED_PACKET_PARSER_MACROS_SVH
`define SYNC_FRAMED_PACKET_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SFPP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SFPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sfpp_pkg.sv =====
// Types and constants of the framed packet parser.
package sfpp_pkg;

    // Fixed field widths of the two channels.
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned OFFSET_W = 7;
    localparam int unsigned SLOT_W   = 2;
    localparam int unsigned LEN_W    = 16;

    // Command codes on the input channel.
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // Sync pair that opens every frame.
    localparam logic [DATA_W-1:0] SYNC_CHAR1 = 8'hB5;
    localparam logic [DATA_W-1:0] SYNC_CHAR2 = 8'h62;

    // Parser phases, one-hot.
    typedef enum logic [7:0] {
        PH_SYNC1   = 8'b0000_0001,
        PH_SYNC2   = 8'b0000_0010,
        PH_CLASS   = 8'b0000_0100,
        PH_ID      = 8'b0000_1000,
        PH_LENGTH  = 8'b0001_0000,
        PH_PAYLOAD = 8'b0010_0000,
        PH_CHECK   = 8'b0100_0000,
        PH_DONE    = 8'b1000_0000
    } t_phase;

    // Status codes reported with each byte.
    typedef enum logic [STATUS_W-1:0] {
        ST_SYNCING  = 3'd0,
        ST_PREAMBLE = 3'd1,
        ST_PARSING  = 3'd2,
        ST_VALID    = 3'd3,
        ST_BADSUM   = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    // One result item as held in the output stage.
    typedef struct packed {
        t_status               status;
        logic                  store_enable;
        logic [OFFSET_W-1:0]   store_offset;
        logic [DATA_W-1:0]     store_byte;
        logic [SLOT_W-1:0]     buffer_slot;
        logic [DATA_W-1:0]     message_class;
        logic [DATA_W-1:0]     message_id;
        logic [LEN_W-1:0]      payload_length;
    } t_result;

endpackage

// ===== sv/sfpp_if.sv =====
// Valid/ready channel interfaces for the parser input and result streams.
interface sfpp_in_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [sfpp_pkg::DATA_W-1:0]   data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface sfpp_out_if;
    logic                            valid;
    logic                            ready;
    logic [sfpp_pkg::STATUS_W-1:0]   status;
    logic                            store_enable;
    logic [sfpp_pkg::OFFSET_W-1:0]   store_offset;
    logic [sfpp_pkg::DATA_W-1:0]     store_byte;
    logic [sfpp_pkg::SLOT_W-1:0]     buffer_slot;
    logic [sfpp_pkg::DATA_W-1:0]     message_class;
    logic [sfpp_pkg::DATA_W-1:0]     message_id;
    logic [sfpp_pkg::LEN_W-1:0]      payload_length;

    modport source (
        output valid, output status, output store_enable, output store_offset,
        output store_byte, output buffer_slot, output message_class,
        output message_id, output payload_length, input ready
    );
    modport sink (
        input valid, input status, input store_enable, input store_offset,
        input store_byte, input buffer_slot, input message_class,
        input message_id, input payload_length, output ready
    );
endinterface

// ===== sv/sync_framed_packet_parser.sv =====
// Top level of the sync-framed packet parser with its Fletcher-8 check.

// The parser takes one received byte or a restart command per input transfer and returns
// exactly one result transfer for each, giving the byte's status, where it goes in the
// current frame buffer slot, and the class, id and length held for the frame. Every item
// is finished in the cycle it is accepted: the phase machine, running checksum and write
// position update at that edge, so one item per clock is sustained while input is ready;
// results are registered. A two-entry output stage (result register plus skid register)
// takes one further transfer after the result side stalls, so the input stops only when
// both are full and resumes in the cycle after the held result leaves; input ready
// depends only on the skid register being free. No clearing pass follows reset.
module sync_framed_packet_parser #(
    parameter int unsigned FRAME_BYTES = 128,
    parameter int unsigned FRAME_SLOTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfpp_in_if.sink     i_in,
    sfpp_out_if.source  o_out
);

    `include "sync_framed_packet_parser_macros.svh"

    localparam int unsigned PW = $clog2(FRAME_BYTES + 1);
    localparam int unsigned SW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
    localparam logic [PW-1:0] POS_FULL  = PW'(FRAME_BYTES);
    localparam logic [SW-1:0] SLOT_LAST = SW'(FRAME_SLOTS - 1);

    // Parser state.
    sfpp_pkg::t_phase                 r_phase,   n_phase;
    logic [sfpp_pkg::LEN_W-1:0]       r_left,    n_left;
    logic [PW-1:0]                    r_pos,     n_pos;
    logic [sfpp_pkg::DATA_W-1:0]      r_sum_a,   n_sum_a;
    logic [sfpp_pkg::DATA_W-1:0]      r_sum_b,   n_sum_b;
    logic [sfpp_pkg::DATA_W-1:0]      r_ck_a,    n_ck_a;
    logic [sfpp_pkg::DATA_W-1:0]      r_class,   n_class;
    logic [sfpp_pkg::DATA_W-1:0]      r_id,      n_id;
    logic [sfpp_pkg::LEN_W-1:0]       r_len,     n_len;
    logic [SW-1:0]                    r_slot,    n_slot;

    // Output stage.
    sfpp_pkg::t_result                r_out,  r_skid, res;
    logic                             r_out_valid, r_skid_valid;

    logic                             accept, out_fire, store;
    logic [sfpp_pkg::DATA_W-1:0]      b, add_a, add_b;
    logic [sfpp_pkg::LEN_W-1:0]       len_full, left_dec;
    logic [PW-1:0]                    offset;
    logic [PW+sfpp_pkg::OFFSET_W-1:0] offset_ext;
    logic [SW+sfpp_pkg::SLOT_W-1:0]   slot_ext;
    sfpp_pkg::t_status                status;

    // Conditions used by the checks at the end.
    logic                             restart_in, parser_clear, out_store, store_ok;
    logic                             in_payload;

    assign accept   = i_in.valid & i_in.ready;
    assign out_fire = r_out_valid & o_out.ready;
    assign i_in.ready = ~r_skid_valid;

    // Running Fletcher-8 terms and length helpers for the current byte.
    assign b        = i_in.data_byte;
    assign add_a    = r_sum_a + b;
    assign add_b    = r_sum_b + add_a;
    assign len_full = {b, r_len[7:0]};
    assign left_dec = r_left - 16'd1;

    // Phase machine: next state and result for the byte on the input.
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_pos   = r_pos;
        n_sum_a = r_sum_a;
        n_sum_b = r_sum_b;
        n_ck_a  = r_ck_a;
        n_class = r_class;
        n_id    = r_id;
        n_len   = r_len;
        n_slot  = r_slot;
        store   = 1'b0;
        status  = sfpp_pkg::ST_SYNCING;
        offset  = r_pos;

        if (i_in.cmd == sfpp_pkg::CMD_RESTART) begin
            n_phase = sfpp_pkg::PH_SYNC1;
            n_left  = '0;
            n_pos   = '0;
            n_sum_a = '0;
            n_sum_b = '0;
            n_ck_a  = '0;
            n_class = '0;
            n_id    = '0;
            n_len   = '0;
            n_slot  = (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
            offset  = '0;
        end else if (r_pos >= POS_FULL || r_phase == sfpp_pkg::PH_DONE) begin
            status = sfpp_pkg::ST_OVERFLOW;
        end else begin
            case (r_phase)
                sfpp_pkg::PH_SYNC1: begin
                    if (b == sfpp_pkg::SYNC_CHAR1) begin
                        n_phase = sfpp_pkg::PH_SYNC2;
                        n_sum_a = '0;
                        n_sum_b = '0;
                        store   = 1'b1;
                        status  = sfpp_pkg::ST_PREAMBLE;
                    end
                end
                sfpp_pkg::PH_SYNC2: begin
                    if (b == sfpp_pkg::SYNC_CHAR2) begin
                        n_phase = sfpp_pkg::PH_CLASS;
                        store   = 1'b1;
                        status  = sfpp_pkg::ST_PREAMBLE;
                    end else begin
                        // A broken sync pair rewinds to the start of the slot.
                        n_phase = sfpp_pkg::PH_SYNC1;
                        n_pos   = '0;
                        offset  = '0;
                    end
                end
                sfpp_pkg::PH_CLASS: begin
                    n_class = b;
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    n_phase = sfpp_pkg::PH_ID;
                    store   = 1'b1;
                    status  = sfpp_pkg::ST_PARSING;
                end
                sfpp_pkg::PH_ID: begin
                    n_id    = b;
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    n_phase = sfpp_pkg::PH_LENGTH;
                    n_left  = 16'd2;
                    store   = 1'b1;
                    status  = sfpp_pkg::ST_PARSING;
                end
                sfpp_pkg::PH_LENGTH: begin
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    if (r_left == 16'd2) begin
                        n_len  = {8'd0, b};
                        n_left = 16'd1;
                    end else begin
                        n_len = len_full;
                        // An empty payload goes straight to the check bytes.
                        if (len_full == '0) begin
                            n_phase = sfpp_pkg::PH_CHECK;
                            n_left  = 16'd2;
                        end else begin
                            n_phase = sfpp_pkg::PH_PAYLOAD;
                            n_left  = len_full;
                        end
                    end
                    store  = 1'b1;
                    status = sfpp_pkg::ST_PARSING;
                end
                sfpp_pkg::PH_PAYLOAD: begin
                    n_sum_a = add_a;
                    n_sum_b = add_b;
                    n_left  = left_dec;
                    if (left_dec == '0) begin
                        n_phase = sfpp_pkg::PH_CHECK;
                        n_left  = 16'd2;
                    end
                    store  = 1'b1;
                    status = sfpp_pkg::ST_PARSING;
                end
                default: begin
                    // Check bytes: hold ckA, then compare both with the running sums.
                    store = 1'b1;
                    if (r_left == 16'd2) begin
                        n_ck_a = b;
                        n_left = 16'd1;
                        status = sfpp_pkg::ST_PARSING;
                    end else begin
                        status  = (r_ck_a == r_sum_a && b == r_sum_b) ?
                                  sfpp_pkg::ST_VALID : sfpp_pkg::ST_BADSUM;
                        n_phase = sfpp_pkg::PH_DONE;
                        n_left  = '0;
                    end
                end
            endcase
            if (store) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    // Result item assembled from the updated state.
    assign offset_ext = {{sfpp_pkg::OFFSET_W{1'b0}}, offset};
    assign slot_ext   = {{sfpp_pkg::SLOT_W{1'b0}}, n_slot};

    always_comb begin
        res.status         = status;
        res.store_enable   = store;
        res.store_offset   = offset_ext[sfpp_pkg::OFFSET_W-1:0];
        res.store_byte     = store ? b : '0;
        res.buffer_slot    = slot_ext[sfpp_pkg::SLOT_W-1:0];
        res.message_class  = n_class;
        res.message_id     = n_id;
        res.payload_length = n_len;
    end

    // Parser state registers, updated on every accepted transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sfpp_pkg::PH_SYNC1;
            r_left  <= '0;
            r_pos   <= '0;
            r_sum_a <= '0;
            r_sum_b <= '0;
            r_ck_a  <= '0;
            r_class <= '0;
            r_id    <= '0;
            r_len   <= '0;
            r_slot  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_pos   <= n_pos;
            r_sum_a <= n_sum_a;
            r_sum_b <= n_sum_b;
            r_ck_a  <= n_ck_a;
            r_class <= n_class;
            r_id    <= n_id;
            r_len   <= n_len;
            r_slot  <= n_slot;
        end
    end

    // Output stage control: the skid register catches a result while the output stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= accept;
            end
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output stage payload.
    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= res;
            end
        end else if (accept) begin
            r_skid <= res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.store_enable   = r_out.store_enable;
    assign o_out.store_offset   = r_out.store_offset;
    assign o_out.store_byte     = r_out.store_byte;
    assign o_out.buffer_slot    = r_out.buffer_slot;
    assign o_out.message_class  = r_out.message_class;
    assign o_out.message_id     = r_out.message_id;
    assign o_out.payload_length = r_out.payload_length;

    // Terms for the checks below.
    assign restart_in   = accept && (i_in.cmd == sfpp_pkg::CMD_RESTART);
    assign parser_clear = (r_phase == sfpp_pkg::PH_SYNC1) && (r_pos == '0);
    assign out_store    = o_out.valid && o_out.store_enable;
    assign store_ok     = (o_out.status != sfpp_pkg::ST_SYNCING) &&
                          (o_out.status != sfpp_pkg::ST_OVERFLOW);
    assign in_payload   = (r_phase == sfpp_pkg::PH_PAYLOAD);

    // The skid register is only ever filled behind a held result.
    `SFPP_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "orphan skid")
    // A stored byte is never reported as hunting or overflow.
    `SFPP_ASSERT_NOW(a_store_status, i_clk, i_rst_n, out_store, store_ok, "store status")
    // A restart leaves the parser hunting at the start of the slot.
    `SFPP_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n, restart_in, parser_clear, "restart failed")
    // The write position never runs past the end of the buffer slot.
    `SFPP_ASSERT_NOW(a_pos_bound, i_clk, i_rst_n, 1'b1, r_pos <= POS_FULL, "position overrun")
    // While in the payload there is always at least one byte still to come.
    `SFPP_ASSERT_NOW(a_payload_left, i_clk, i_rst_n, in_payload, r_left != '0, "no bytes left")

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the sync-framed packet parser: directed table, random frames.
module tb;
    import sfpp_pkg::*;

    localparam int unsigned FRAME_BYTES    = 128;
    localparam int unsigned FRAME_SLOTS    = 4;
    localparam int unsigned ITEM_TARGET    = 1250;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned TAIL_CYCLES    = 8;

    // One row of the directed table; the result is pinned only where it is obvious.
    typedef struct {
        logic        cmd;
        logic [7:0]  data;
        bit          pinned;
        t_result     want;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;

    sfpp_in_if  byte_ch ();
    sfpp_out_if report_ch ();

    sync_framed_packet_parser #(
        .FRAME_BYTES (FRAME_BYTES),
        .FRAME_SLOTS (FRAME_SLOTS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_ch),
        .o_out   (report_ch)
    );

    // Parser state as the predictor sees it.
    t_phase       frame_phase;
    logic [15:0]  bytes_to_go;
    int unsigned  buffer_fill;
    logic [7:0]   fletcher_a;
    logic [7:0]   fletcher_b;
    logic [7:0]   held_ck_a;
    logic [7:0]   held_class;
    logic [7:0]   held_id;
    logic [15:0]  held_length;
    int unsigned  slot_now;

    // Reports still owed by the parser, oldest first.
    t_result      parser_reports [$];
    t_result      predicted;
    t_result      observed;
    t_result      pinned_result;
    bit           pinned_known;

    t_directed_row directed_rows [26];

    int unsigned  send_gap_pct;
    int unsigned  recv_stall_pct;
    int unsigned  sent_items;
    int unsigned  mismatch_count;
    int unsigned  stalled_cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Clears everything that a restart clears, leaving the slot alone.
    function automatic void clear_frame_state();
        frame_phase = PH_SYNC1;
        bytes_to_go = '0;
        buffer_fill = 0;
        fletcher_a  = '0;
        fletcher_b  = '0;
        held_ck_a   = '0;
        held_class  = '0;
        held_id     = '0;
        held_length = '0;
    endfunction

    function automatic void fold_into_sum(input logic [7:0] b);
        fletcher_a = fletcher_a + b;
        fletcher_b = fletcher_b + fletcher_a;
    endfunction

    // Advances the parser by one transfer and returns the report it owes for it.
    function automatic t_result advance_parser(input logic cmd, input logic [7:0] b);
        t_result r;
        logic    taken;
        r        = '0;
        r.status = ST_SYNCING;
        taken    = 1'b0;
        if (cmd == CMD_RESTART) begin
            clear_frame_state();
            slot_now = (slot_now + 1) % FRAME_SLOTS;
        end else if (buffer_fill >= FRAME_BYTES || frame_phase == PH_DONE) begin
            r.status       = ST_OVERFLOW;
            r.store_offset = buffer_fill[6:0];
        end else begin
            r.store_offset = buffer_fill[6:0];
            case (frame_phase)
                PH_SYNC1: begin
                    if (b == SYNC_CHAR1) begin
                        frame_phase = PH_SYNC2;
                        fletcher_a  = '0;
                        fletcher_b  = '0;
                        taken       = 1'b1;
                        r.status    = ST_PREAMBLE;
                    end
                end
                PH_SYNC2: begin
                    if (b == SYNC_CHAR2) begin
                        frame_phase = PH_CLASS;
                        taken       = 1'b1;
                        r.status    = ST_PREAMBLE;
                    end else begin
                        // A broken sync pair starts the hunt again from offset zero.
                        frame_phase    = PH_SYNC1;
                        buffer_fill    = 0;
                        r.store_offset = '0;
                    end
                end
                PH_CLASS: begin
                    held_class = b;
                    fold_into_sum(b);
                    frame_phase = PH_ID;
                    taken       = 1'b1;
                    r.status    = ST_PARSING;
                end
                PH_ID: begin
                    held_id = b;
                    fold_into_sum(b);
                    frame_phase = PH_LENGTH;
                    bytes_to_go = 16'd2;
                    taken       = 1'b1;
                    r.status    = ST_PARSING;
                end
                PH_LENGTH: begin
                    fold_into_sum(b);
                    if (bytes_to_go == 16'd2) begin
                        held_length = {8'h00, b};
                        bytes_to_go = 16'd1;
                    end else begin
                        held_length = {b, held_length[7:0]};
                        // An empty payload goes straight to the check bytes.
                        if (held_length == 16'd0) begin
                            frame_phase = PH_CHECK;
                            bytes_to_go = 16'd2;
                        end else begin
                            frame_phase = PH_PAYLOAD;
                            bytes_to_go = held_length;
                        end
                    end
                    taken    = 1'b1;
                    r.status = ST_PARSING;
                end
                PH_PAYLOAD: begin
                    fold_into_sum(b);
                    bytes_to_go = bytes_to_go - 16'd1;
                    if (bytes_to_go == 16'd0) begin
                        frame_phase = PH_CHECK;
                        bytes_to_go = 16'd2;
                    end
                    taken    = 1'b1;
                    r.status = ST_PARSING;
                end
                default: begin
                    taken = 1'b1;
                    if (bytes_to_go == 16'd2) begin
                        held_ck_a   = b;
                        bytes_to_go = 16'd1;
                        r.status    = ST_PARSING;
                    end else begin
                        r.status    = (held_ck_a == fletcher_a && b == fletcher_b) ?
                                      ST_VALID : ST_BADSUM;
                        frame_phase = PH_DONE;
                        bytes_to_go = '0;
                    end
                end
            endcase
            if (taken) begin
                buffer_fill = buffer_fill + 1;
            end
        end
        r.store_enable   = taken;
        r.store_byte     = taken ? b : 8'h00;
        r.buffer_slot    = slot_now[1:0];
        r.message_class  = held_class;
        r.message_id     = held_id;
        r.payload_length = held_length;
        return r;
    endfunction

    task automatic check_report(input t_result want, input t_result got);
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatch_count++;
        end
        if (got.store_enable !== want.store_enable) begin
            $error("store_enable: expected %0d, got %0d", want.store_enable, got.store_enable);
            mismatch_count++;
        end
        if (got.store_offset !== want.store_offset) begin
            $error("store_offset: expected %0d, got %0d", want.store_offset, got.store_offset);
            mismatch_count++;
        end
        if (got.store_byte !== want.store_byte) begin
            $error("store_byte: expected %0h, got %0h", want.store_byte, got.store_byte);
            mismatch_count++;
        end
        if (got.buffer_slot !== want.buffer_slot) begin
            $error("buffer_slot: expected %0d, got %0d", want.buffer_slot, got.buffer_slot);
            mismatch_count++;
        end
        if (got.message_class !== want.message_class) begin
            $error("message_class: expected %0h, got %0h", want.message_class,
                   got.message_class);
            mismatch_count++;
        end
        if (got.message_id !== want.message_id) begin
            $error("message_id: expected %0h, got %0h", want.message_id, got.message_id);
            mismatch_count++;
        end
        if (got.payload_length !== want.payload_length) begin
            $error("payload_length: expected %0h, got %0h", want.payload_length,
                   got.payload_length);
            mismatch_count++;
        end
    endtask

    // Predict on each input transfer and check each result transfer at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            stalled_cycles = stalled_cycles + 1;
            if (byte_ch.valid && byte_ch.ready) begin
                predicted = advance_parser(byte_ch.cmd, byte_ch.data_byte);
                parser_reports.push_back(pinned_known ? pinned_result : predicted);
                sent_items++;
                stalled_cycles = 0;
            end
            if (report_ch.valid && report_ch.ready) begin
                observed = {report_ch.status, report_ch.store_enable, report_ch.store_offset,
                            report_ch.store_byte, report_ch.buffer_slot,
                            report_ch.message_class, report_ch.message_id,
                            report_ch.payload_length};
                if (parser_reports.size() == 0) begin
                    $error("result transfer with no report outstanding");
                    mismatch_count++;
                end else begin
                    check_report(parser_reports.pop_front(), observed);
                end
                stalled_cycles = 0;
            end
        end
    end

    // The receiver stalls at random at the rate of the current phase.
    always @(negedge i_clk) begin
        report_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Ends the run when nothing has moved for too long.
    initial begin
        while (stalled_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("sync_framed_packet_parser test failed");
        $finish;
    end

    // Offers one transfer after a random gap and holds it until it is taken.
    task automatic send_item(input logic cmd, input logic [7:0] data);
        while ($urandom_range(99) < send_gap_pct) begin
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid     <= 1'b1;
        byte_ch.cmd       <= cmd;
        byte_ch.data_byte <= data;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // A well-formed frame with random content, mostly with a correct checksum.
    task automatic send_frame();
        logic [7:0]  body [$];
        logic [7:0]  ck_a;
        logic [7:0]  ck_b;
        logic [7:0]  junk;
        logic [15:0] len;
        int unsigned pick;
        int unsigned count;
        ck_a = '0;
        ck_b = '0;
        if ($urandom_range(99) < 85) begin
            send_item(CMD_RESTART, 8'($urandom));
        end
        repeat ($urandom_range(2)) begin
            junk = 8'($urandom);
            if (junk == SYNC_CHAR1) begin
                junk = 8'h00;
            end
            send_item(CMD_BYTE, junk);
        end
        // Mostly short payloads; some fill the buffer, a few carry a wild length.
        pick = $urandom_range(99);
        if (pick < 8) begin
            len = '0;
        end else if (pick < 80) begin
            len = 16'($urandom_range(16, 1));
        end else if (pick < 92) begin
            len = 16'($urandom_range(130, 100));
        end else begin
            len = 16'($urandom);
        end
        count = (len > 130) ? 130 : len;
        body.push_back(8'($urandom));
        body.push_back(8'($urandom));
        body.push_back(len[7:0]);
        body.push_back(len[15:8]);
        repeat (count) body.push_back(8'($urandom));
        send_item(CMD_BYTE, SYNC_CHAR1);
        send_item(CMD_BYTE, SYNC_CHAR2);
        foreach (body[k]) begin
            ck_a = ck_a + body[k];
            ck_b = ck_b + ck_a;
            send_item(CMD_BYTE, body[k]);
        end
        if ($urandom_range(99) < 20) begin
            if ($urandom_range(1)) begin
                ck_a = ck_a ^ (8'd1 << $urandom_range(7));
            end else begin
                ck_b = ck_b ^ (8'd1 << $urandom_range(7));
            end
        end
        send_item(CMD_BYTE, ck_a);
        send_item(CMD_BYTE, ck_b);
        repeat ($urandom_range(2)) send_item(CMD_BYTE, 8'($urandom));
    endtask

    // Noise, broken sync pairs, lone restarts and truncated frames.
    task automatic send_noise();
        logic [7:0] b;
        case ($urandom_range(3))
            0: begin
                repeat ($urandom_range(6, 1)) begin
                    b = ($urandom_range(3) == 0) ? SYNC_CHAR1 : 8'($urandom);
                    send_item(CMD_BYTE, b);
                end
            end
            1: begin
                b = $urandom_range(1) ? SYNC_CHAR1 : 8'($urandom);
                if (b == SYNC_CHAR2) begin
                    b = 8'h00;
                end
                send_item(CMD_BYTE, SYNC_CHAR1);
                send_item(CMD_BYTE, b);
            end
            2: begin
                send_item(CMD_RESTART, 8'($urandom));
            end
            default: begin
                send_item(CMD_BYTE, SYNC_CHAR1);
                send_item(CMD_BYTE, SYNC_CHAR2);
                repeat ($urandom_range(5)) send_item(CMD_BYTE, 8'($urandom));
            end
        endcase
    endtask

    initial begin
        int unsigned goal;
        int unsigned gap_by_phase [3];
        int unsigned stall_by_phase [3];
        gap_by_phase   = '{24, 73, 0};
        stall_by_phase = '{73, 24, 0};
        directed_rows = '{
            '{CMD_BYTE,    8'h00, 1'b1, '{ST_SYNCING, 1'b0, 7'd0, 8'h00, 2'd0, 8'h00, 8'h00, 16'h0000}},
            '{CMD_BYTE,    8'hFF, 1'b1, '{ST_SYNCING, 1'b0, 7'd0, 8'h00, 2'd0, 8'h00, 8'h00, 16'h0000}},
            '{CMD_RESTART, 8'h00, 1'b1, '{ST_SYNCING, 1'b0, 7'd0, 8'h00, 2'd1, 8'h00, 8'h00, 16'h0000}},
            '{CMD_BYTE,    8'hB5, 1'b1, '{ST_PREAMBLE, 1'b1, 7'd0, 8'hB5, 2'd1, 8'h00, 8'h00, 16'h0000}},
            '{CMD_BYTE,    8'h00, 1'b1, '{ST_SYNCING, 1'b0, 7'd0, 8'h00, 2'd1, 8'h00, 8'h00, 16'h0000}},
            // Empty payload with the extreme class byte and a good checksum.
            '{CMD_BYTE,    8'hB5, 1'b0, '0},
            '{CMD_BYTE,    8'h62, 1'b0, '0},
            '{CMD_BYTE,    8'hFF, 1'b0, '0},
            '{CMD_BYTE,    8'h00, 1'b0, '0},
            '{CMD_BYTE,    8'h00, 1'b0, '0},
            '{CMD_BYTE,    8'h00, 1'b0, '0},
            '{CMD_BYTE,    8'hFF, 1'b0, '0},
            '{CMD_BYTE,    8'hFC, 1'b1, '{ST_VALID, 1'b1, 7'd7, 8'hFC, 2'd1, 8'hFF, 8'h00, 16'h0000}},
            '{CMD_BYTE,    8'h12, 1'b1, '{ST_OVERFLOW, 1'b0, 7'd8, 8'h00, 2'd1, 8'hFF, 8'h00, 16'h0000}},
            // One payload byte and a wrong checksum.
            '{CMD_RESTART, 8'hFF, 1'b0, '0},
            '{CMD_BYTE,    8'hB5, 1'b0, '0},
            '{CMD_BYTE,    8'h62, 1'b0, '0},
            '{CMD_BYTE,    8'h01, 1'b0, '0},
            '{CMD_BYTE,    8'h02, 1'b0, '0},
            '{CMD_BYTE,    8'h01, 1'b0, '0},
            '{CMD_BYTE,    8'h00, 1'b0, '0},
            '{CMD_BYTE,    8'hAA, 1'b0, '0},
            '{CMD_BYTE,    8'h00, 1'b0, '0},
            '{CMD_BYTE,    8'h00, 1'b1, '{ST_BADSUM, 1'b1, 7'd8, 8'h00, 2'd2, 8'h01, 8'h02, 16'h0001}},
            // The slot wraps back to zero.
            '{CMD_RESTART, 8'h00, 1'b1, '{ST_SYNCING, 1'b0, 7'd0, 8'h00, 2'd3, 8'h00, 8'h00, 16'h0000}},
            '{CMD_RESTART, 8'h00, 1'b1, '{ST_SYNCING, 1'b0, 7'd0, 8'h00, 2'd0, 8'h00, 8'h00, 16'h0000}}
        };

        i_rst_n           = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.cmd       = CMD_BYTE;
        byte_ch.data_byte = '0;
        report_ch.ready   = 1'b0;
        pinned_known      = 1'b0;
        pinned_result     = '0;
        send_gap_pct      = gap_by_phase[0];
        recv_stall_pct    = stall_by_phase[0];
        sent_items        = 0;
        mismatch_count    = 0;
        stalled_cycles    = 0;
        clear_frame_state();
        slot_now = 0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table first, then random traffic under three idling patterns.
        for (int p = 0; p < 3; p++) begin
            send_gap_pct   = gap_by_phase[p];
            recv_stall_pct = stall_by_phase[p];
            if (p == 0) begin
                foreach (directed_rows[k]) begin
                    pinned_known  = directed_rows[k].pinned;
                    pinned_result = directed_rows[k].want;
                    send_item(directed_rows[k].cmd, directed_rows[k].data);
                end
                pinned_known = 1'b0;
                sent_items   = 0;
            end
            goal = sent_items + ITEM_TARGET / 3;
            while (sent_items < goal) begin
                if ($urandom_range(99) < 80) begin
                    send_frame();
                end else begin
                    send_noise();
                end
            end
        end
        byte_ch.valid <= 1'b0;

        // Drain the outstanding reports, then allow for the output stage to settle.
        while (parser_reports.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("sync_framed_packet_parser test passed");
        end else begin
            $display("sync_framed_packet_parser test failed");
        end
        $finish;
    end
endmodule
